FILE: rtl/core/gjls_pkg.sv
`default_nettype none
package gjls_pkg;

  localparam int MaxUnknowns = 8;
  localparam int StoreDepth  = MaxUnknowns * (MaxUnknowns + 1);
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int IdxW        = $clog2(MaxUnknowns);
  localparam int ColW        = $clog2(MaxUnknowns + 1);
  localparam int OrderW      = 4;

  localparam logic [31:0] SatMax = 32'h7fff_ffff;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PIV_RD,
    ST_PIV_CHK,
    ST_RAT_RD,
    ST_RAT_DIV,
    ST_ROW_RD,
    ST_ROW_MUL,
    ST_ROW_WR,
    ST_FIN_RD,
    ST_FIN_CHK,
    ST_SOL_RD,
    ST_SOL_DIV,
    ST_EMIT,
    ST_SING
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PIVOT,
    RD_OTHER,
    RD_ROWI,
    RD_ROWJ,
    RD_RHS
  } rd_sel_t;

  typedef struct packed {
    logic             load_wr;
    logic [AddrW-1:0] load_addr;
    rd_sel_t          rd_sel;
    logic [AddrW-1:0] rd_addr;
    logic             div_start;
    logic             div_sol;
    logic             mul_start;
    logic             row_wr;
    logic [AddrW-1:0] wr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic        pivot_zero;
    logic        ratio_zero;
    logic        div_busy;
    logic        mul_busy;
    logic [31:0] quotient;
  } dp_sts_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = SatMax;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = SatMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gjls_div.sv
`default_nettype none
// Signed 48/32 divider, one quotient bit a cycle, truncating toward zero,
// saturated to 32 bits.
module gjls_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] num_in,
  input  wire logic [31:0] den_in,
  output logic             busy,
  output logic [31:0]      quo
);

  logic [47:0] rem_q;
  logic [47:0] qbits;
  logic [31:0] dmag;
  logic        neg;
  logic [5:0]  cnt;
  logic [48:0] trial;
  logic [47:0] shifted;

  always_comb begin
    shifted = {rem_q[46:0], qbits[47]};
    trial   = {1'b0, shifted} - {17'd0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd48;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      qbits <= num_in[47] ? (~num_in + 48'd1) : num_in;
      dmag  <= den_in[31] ? (~den_in + 32'd1) : den_in;
      neg   <= num_in[47] ^ den_in[31];
    end else if (busy) begin
      if (!trial[48]) begin
        rem_q <= trial[47:0];
        qbits <= {qbits[46:0], 1'b1};
      end else begin
        rem_q <= shifted;
        qbits <= {qbits[46:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic signed [63:0] sv;
    sv  = neg ? -$signed({16'd0, qbits}) : $signed({16'd0, qbits});
    quo = gjls_pkg::sat32(sv);
  end

endmodule
`default_nettype wire

FILE: rtl/core/gjls_datapath.sv
`default_nettype none
// Matrix memory, pivot/ratio/row registers, divider and a two-stage
// 32x32 multiplier for the row update.
module gjls_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [31:0]         coefficient,
  input  wire gjls_pkg::dp_cmd_t   cmd,
  output gjls_pkg::dp_sts_t        sts
);

  logic [31:0] mem [gjls_pkg::StoreDepth];
  logic [31:0] rd_data;
  gjls_pkg::rd_sel_t sel_q;
  logic [31:0] pivot;
  logic [31:0] other;
  logic [31:0] ratio;
  logic [31:0] rowi;
  logic [31:0] rowj;
  logic [31:0] rhs;
  logic signed [63:0] prod;
  logic [1:0]  mstage;
  logic [31:0] upd;
  logic [47:0] div_num;
  logic [31:0] div_den;
  logic        div_busy;
  logic [31:0] quo;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[cmd.load_addr] <= coefficient;
    end else if (cmd.row_wr) begin
      mem[cmd.wr_addr] <= upd;
    end
    rd_data <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_q <= gjls_pkg::RD_NONE;
    end else begin
      sel_q <= cmd.rd_sel;
    end
  end

  always_ff @(posedge clk) begin
    case (sel_q)
      gjls_pkg::RD_PIVOT: pivot <= rd_data;
      gjls_pkg::RD_OTHER: other <= rd_data;
      gjls_pkg::RD_ROWI:  rowi  <= rd_data;
      gjls_pkg::RD_ROWJ:  rowj  <= rd_data;
      gjls_pkg::RD_RHS:   rhs   <= rd_data;
      default: ;
    endcase
    if (!div_busy && !cmd.div_start && !cmd.div_sol) begin
      ratio <= quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstage <= '0;
    end else begin
      mstage <= {mstage[0], cmd.mul_start};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod <= $signed(ratio) * $signed(rowi);
    end
    if (mstage[0]) begin
      logic signed [63:0] q;
      logic signed [63:0] d;
      q = (prod + ((prod < 0) ? 64'sd65535 : 64'sd0)) >>> 16;
      d = $signed({{32{rowj[31]}}, rowj}) - q;
      upd <= gjls_pkg::sat32(d);
    end
  end

  always_comb begin
    div_den = pivot;
    if (cmd.div_sol) begin
      div_num = {rhs, 16'd0};
    end else begin
      div_num = {other, 16'd0};
    end
  end

  gjls_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num_in (div_num),
    .den_in (div_den),
    .busy   (div_busy),
    .quo    (quo)
  );

  always_comb begin
    sts.pivot_zero = (pivot == 32'd0);
    sts.ratio_zero = (quo == 32'd0);
    sts.div_busy   = div_busy;
    sts.mul_busy   = |mstage;
    sts.quotient   = quo;
  end

endmodule
`default_nettype wire

FILE: rtl/core/gjls_ctrl.sv
`default_nettype none
// Sequencer: loading, elimination loops i/j/k, final checks and output.
module gjls_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [3:0]           order,
  input  wire logic                 cfg_wr,
  input  wire logic                 in_fire,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_sol,
  output logic [2:0]                out_idx,
  output logic                      out_last,
  output logic                      out_sing,
  output gjls_pkg::dp_cmd_t         cmd,
  input  wire gjls_pkg::dp_sts_t    sts
);

  localparam int AW = gjls_pkg::AddrW;

  gjls_pkg::state_t state, state_next;
  logic [AW-1:0] load_pos;
  logic [3:0]    ci, cj, ck;
  logic [3:0]    n;
  logic [3:0]    w;
  logic [AW-1:0] total;
  logic          ovalid;
  logic [31:0]   osol;
  logic [2:0]    oidx;
  logic          olast, osing;
  logic [3:0]    ci_next, cj_next, ck_next;

  always_comb begin
    if (order == 4'd0) begin
      n = 4'd1;
    end else if (order > 4'(gjls_pkg::MaxUnknowns)) begin
      n = 4'(gjls_pkg::MaxUnknowns);
    end else begin
      n = order;
    end
    w     = n + 4'd1;
    total = AW'(n) * AW'(w);
  end

  function automatic logic [AW-1:0] addr(input logic [3:0] r, input logic [3:0] c,
                                         input logic [3:0] wd);
    return AW'(r * wd + {4'd0, c});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gjls_pkg::ST_LOAD;
      load_pos <= '0;
      ovalid   <= 1'b0;
    end else begin
      state <= state_next;
      ci    <= ci_next;
      cj    <= cj_next;
      ck    <= ck_next;
      if (cfg_wr) begin
        load_pos <= '0;
      end else if (in_fire) begin
        load_pos <= (load_pos + AW'(1) >= total) ? '0 : load_pos + AW'(1);
      end
      if (state == gjls_pkg::ST_EMIT && (!ovalid || out_ready)) begin
        ovalid <= 1'b1;
        osol   <= sts.quotient;
        oidx   <= ci[2:0];
        olast  <= (ci + 4'd1 == n);
        osing  <= 1'b0;
      end else if (state == gjls_pkg::ST_SING && (!ovalid || out_ready)) begin
        ovalid <= 1'b1;
        osol   <= '0;
        oidx   <= ci[2:0];
        olast  <= 1'b1;
        osing  <= 1'b1;
      end else if (ovalid && out_ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    ci_next       = ci;
    cj_next       = cj;
    ck_next       = ck;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.rd_sel    = gjls_pkg::RD_NONE;
    cmd.load_addr = load_pos;
    unique case (state)
      gjls_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_wr = 1'b1;
          if (load_pos + AW'(1) >= total) begin
            ci_next    = '0;
            state_next = gjls_pkg::ST_PIV_RD;
          end
        end
      end
      gjls_pkg::ST_PIV_RD: begin
        cmd.rd_addr = addr(ci, ci, w);
        cmd.rd_sel  = gjls_pkg::RD_PIVOT;
        cj_next     = '0;
        ck_next     = 4'd1;
        state_next  = gjls_pkg::ST_PIV_CHK;
      end
      gjls_pkg::ST_PIV_CHK: begin
        // wait while the registered read passes through rd_data into pivot
        if (ck != 4'd0) begin
          ck_next = 4'd0;
        end else if (sts.pivot_zero) begin
          state_next = gjls_pkg::ST_SING;
        end else begin
          state_next = gjls_pkg::ST_RAT_RD;
        end
      end
      gjls_pkg::ST_RAT_RD: begin
        if (cj >= n) begin
          if (ci + 4'd1 >= n) begin
            ci_next    = '0;
            state_next = gjls_pkg::ST_FIN_RD;
          end else begin
            ci_next    = ci + 4'd1;
            state_next = gjls_pkg::ST_PIV_RD;
          end
        end else if (cj == ci) begin
          cj_next = cj + 4'd1;
        end else begin
          cmd.rd_addr = addr(cj, ci, w);
          cmd.rd_sel  = gjls_pkg::RD_OTHER;
          ck_next     = 4'd15;
          state_next  = gjls_pkg::ST_RAT_DIV;
        end
      end
      gjls_pkg::ST_RAT_DIV: begin
        // ck counts a short wait for the read, then the divide
        if (ck == 4'd15) begin
          ck_next = 4'd14;
        end else if (ck == 4'd14) begin
          cmd.div_start = 1'b1;
          ck_next       = 4'd13;
        end else if (!sts.div_busy) begin
          if (sts.ratio_zero) begin
            cj_next    = cj + 4'd1;
            state_next = gjls_pkg::ST_RAT_RD;
          end else begin
            ck_next    = '0;
            state_next = gjls_pkg::ST_ROW_RD;
          end
        end
      end
      gjls_pkg::ST_ROW_RD: begin
        cmd.rd_addr = addr(ci, ck, w);
        cmd.rd_sel  = gjls_pkg::RD_ROWI;
        state_next  = gjls_pkg::ST_ROW_MUL;
      end
      gjls_pkg::ST_ROW_MUL: begin
        cmd.rd_addr   = addr(cj, ck, w);
        cmd.rd_sel    = gjls_pkg::RD_ROWJ;
        state_next    = gjls_pkg::ST_ROW_WR;
      end
      gjls_pkg::ST_ROW_WR: begin
        // rowi ready now; rowj lands next cycle, multiply in parallel
        cmd.mul_start = 1'b1;
        state_next    = gjls_pkg::ST_FIN_CHK;
      end
      gjls_pkg::ST_FIN_CHK: begin
        // row update pipeline (cj < n) or final diagonal check (cj >= n)
        if (cj < n) begin
          if (!sts.mul_busy) begin
            cmd.row_wr  = 1'b1;
            cmd.wr_addr = addr(cj, ck, w);
            if (ck + 4'd1 >= w) begin
              cj_next    = cj + 4'd1;
              state_next = gjls_pkg::ST_RAT_RD;
            end else begin
              ck_next    = ck + 4'd1;
              state_next = gjls_pkg::ST_ROW_RD;
            end
          end
        end else begin
          if (ck != 4'd0) begin
            ck_next = 4'd0;
          end else if (sts.pivot_zero) begin
            state_next = gjls_pkg::ST_SING;
          end else if (ci + 4'd1 >= n) begin
            ci_next    = '0;
            state_next = gjls_pkg::ST_SOL_RD;
          end else begin
            ci_next    = ci + 4'd1;
            state_next = gjls_pkg::ST_FIN_RD;
          end
        end
      end
      gjls_pkg::ST_FIN_RD: begin
        cmd.rd_addr = addr(ci, ci, w);
        cmd.rd_sel  = gjls_pkg::RD_PIVOT;
        cj_next     = 4'd15;
        ck_next     = 4'd1;
        state_next  = gjls_pkg::ST_FIN_CHK;
      end
      gjls_pkg::ST_SOL_RD: begin
        cmd.rd_addr = addr(ci, ci, w);
        cmd.rd_sel  = gjls_pkg::RD_PIVOT;
        ck_next     = 4'd15;
        state_next  = gjls_pkg::ST_SOL_DIV;
      end
      gjls_pkg::ST_SOL_DIV: begin
        if (ck == 4'd15) begin
          cmd.rd_addr = addr(ci, n, w);
          cmd.rd_sel  = gjls_pkg::RD_RHS;
          ck_next     = 4'd14;
        end else if (ck == 4'd14) begin
          ck_next = 4'd13;
        end else if (ck == 4'd13) begin
          cmd.div_sol   = 1'b1;
          cmd.div_start = 1'b1;
          ck_next       = 4'd12;
        end else if (!sts.div_busy) begin
          cmd.div_sol = 1'b1;
          state_next  = gjls_pkg::ST_EMIT;
        end
      end
      gjls_pkg::ST_EMIT: begin
        cmd.div_sol = 1'b1;
        if (!ovalid || out_ready) begin
          if (ci + 4'd1 >= n) begin
            state_next = gjls_pkg::ST_LOAD;
          end else begin
            ci_next    = ci + 4'd1;
            state_next = gjls_pkg::ST_SOL_RD;
          end
        end
      end
      gjls_pkg::ST_SING: begin
        if (!ovalid || out_ready) begin
          state_next = gjls_pkg::ST_LOAD;
        end
      end
      default: state_next = gjls_pkg::ST_LOAD;
    endcase
  end

  assign out_valid = ovalid;
  assign out_sol   = osol;
  assign out_idx   = oidx;
  assign out_last  = olast;
  assign out_sing  = osing;

endmodule
`default_nettype wire

FILE: rtl/core/gauss_jordan_linear_solver.sv
`default_nettype none
// Channel    Direction  Word
// s_axis     in         tdata[31:0] coefficient (signed Q16.16)
// m_axis     out        tdata[31:0] solution, tdata[34:32] unknown_index,
//                       tdata[39:35] zero; tlast last_of_run; tuser singular
// apb        in/out     register 0 at address 0: order (4 bits)
//
// Loading accepts one coefficient per cycle. Elimination runs in the
// controller's loops: each pivot is read and checked, each ratio goes
// through the serial divider, and each row element passes through the
// single read port and the two-stage multiplier; then each unknown gets
// a diagonal check, and the divider forms each solution.
// Reset is synchronous and active high; order returns to 3. The input is
// not taken while a solve runs; a stalled result holds in the output
// register and the solve waits for it.
module gauss_jordan_linear_solver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] coefficient
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] solution, [34:32] unknown_index
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,   // [0] singular
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0] order;
  logic       cfg_wr;
  logic       in_fire;
  logic [31:0] sol;
  logic [2:0]  idx;
  gjls_pkg::dp_cmd_t cmd;
  gjls_pkg::dp_sts_t sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr == 2'd0);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= 4'd3;
    end else if (cfg_wr) begin
      order <= pwdata[3:0];
    end
  end

  assign prdata = (paddr == 2'd0) ? {28'd0, order} : 32'd0;

  gjls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .order     (order),
    .cfg_wr    (cfg_wr),
    .in_fire   (in_fire),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sol   (sol),
    .out_idx   (idx),
    .out_last  (m_axis_tlast),
    .out_sing  (m_axis_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  gjls_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .coefficient (s_axis_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign m_axis_tdata = {5'd0, idx, sol};

endmodule
`default_nettype wire

FILE: rtl/core/gjls_checker.sv
`default_nettype none
module gjls_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser,
  input wire logic        pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[31:0] == 32'd0)
    else $error("singular result malformed");

  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
    else $error("input ready dropped without a word taken");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind gauss_jordan_linear_solver gjls_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
`default_nettype wire
